@@ hdl/lphi_pkg.sv @@
// Shared definitions for the linear probing hash insert block.
// Holds result codes, register indexes and the configuration struct; no dependencies.
package lphi_pkg;

    localparam int CFG_W = 5;
    localparam int STEP_BITS = 4;

    localparam logic [CFG_W-1:0] MODULUS_RESET = 5'd13;
    localparam logic [CFG_W-1:0] LENGTH_RESET = 5'd15;

    localparam int REG_INDEX_W = 1;
    localparam logic [REG_INDEX_W-1:0] REG_HASH_MODULUS = 1'b0;
    localparam logic [REG_INDEX_W-1:0] REG_TABLE_LENGTH = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] hash_modulus;
        logic [CFG_W-1:0] table_length;
    } cfg_t;

endpackage

@@ hdl/lphi_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lphi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/lphi_fifo.sv @@
// Short queue that decouples the hashing front end from the probing back end.
// No dependencies.
module lphi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (32'(count_reg) != DEPTH);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/lphi_front.sv @@
// Front end: accepts an operation and works out its home slot with a shared
// remainder unit, four key bits a cycle. Depends on lphi_pkg.
module lphi_front #(
    parameter int KEY_WIDTH = 31,
    parameter int TABLE_DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lphi_pkg::cfg_t               cfg,
    input  logic                         block,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_func,
    input  logic [KEY_WIDTH-1:0]         in_key,
    output logic                         job_valid,
    input  logic                         job_ready,
    output logic                         job_func,
    output logic [KEY_WIDTH-1:0]         job_key,
    output logic [lphi_pkg::CFG_W-1:0]   job_home,
    output logic [lphi_pkg::CFG_W-1:0]   job_len
);

    localparam int LEN_W = lphi_pkg::CFG_W;
    localparam int STEP = lphi_pkg::STEP_BITS;
    localparam int KEY_PAD = ((KEY_WIDTH + STEP - 1) / STEP) * STEP;
    localparam int REM_PAD = ((LEN_W + STEP - 1) / STEP) * STEP;
    localparam int STEPS_KEY = KEY_PAD / STEP;
    localparam int STEPS_REM = REM_PAD / STEP;
    localparam int CNT_W = $clog2(STEPS_KEY + 1);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_KEY  = 2'd1;
    localparam logic [1:0] F_REM  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [KEY_PAD-1:0]   sh_reg;
    logic [LEN_W-1:0]     rem_reg;
    logic [LEN_W-1:0]     div_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic                 func_reg;
    logic [LEN_W-1:0]     rem_step;
    logic [LEN_W-1:0]     eff_mod;
    logic [LEN_W-1:0]     eff_len;
    logic                 accept;
    logic                 last_step;

    // zero modulus acts as one; length is held to 1..TABLE_DEPTH
    assign eff_mod = (cfg.hash_modulus == '0) ? LEN_W'(1) : cfg.hash_modulus;
    assign eff_len = (cfg.table_length == '0) ? LEN_W'(1) :
                     (32'(cfg.table_length) > TABLE_DEPTH) ? LEN_W'(TABLE_DEPTH) :
                     cfg.table_length;

    assign in_ready  = (state_reg == F_IDLE) && !block;
    assign accept    = in_valid && in_ready;
    assign last_step = (cnt_reg == CNT_W'(1));
    assign job_valid = (state_reg == F_PUSH);
    assign job_func  = func_reg;
    assign job_key   = key_reg;
    assign job_home  = rem_reg;
    assign job_len   = len_reg;

    // restoring remainder, most significant bit first
    always_comb
    begin
        logic [LEN_W:0] t;
        rem_step = rem_reg;
        for (int i = 0; i < STEP; i++)
        begin
            t = {rem_step, sh_reg[KEY_PAD-1-i]};
            if (t >= {1'b0, div_reg})
            begin
                t = t - {1'b0, div_reg};
            end
            rem_step = t[LEN_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_KEY;
                end
            end
            F_KEY:
            begin
                if (last_step)
                begin
                    state_next = F_REM;
                end
            end
            F_REM:
            begin
                if (last_step)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (job_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cnt_reg <= CNT_W'(STEPS_KEY);
            end
            else if (state_reg == F_KEY && last_step)
            begin
                cnt_reg <= CNT_W'(STEPS_REM);
            end
            else if (state_reg == F_KEY || state_reg == F_REM)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sh_reg   <= KEY_PAD'(in_key);
            func_reg <= in_func;
            key_reg  <= in_key;
            rem_reg  <= '0;
            div_reg  <= eff_mod;
            len_reg  <= eff_len;
        end
        else if (state_reg == F_KEY && last_step)
        begin
            // reduce the first remainder once more by the table length
            sh_reg  <= KEY_PAD'(rem_step) << (KEY_PAD - REM_PAD);
            rem_reg <= '0;
            div_reg <= len_reg;
        end
        else if (state_reg == F_KEY || state_reg == F_REM)
        begin
            sh_reg  <= sh_reg << STEP;
            rem_reg <= rem_step;
        end
    end

endmodule

@@ hdl/lphi_back.sv @@
// Back end: clears the key table after reset, probes it one slot a cycle,
// stores inserted keys and holds the result register. Depends on lphi_pkg, lphi_ram.
module lphi_back #(
    parameter int KEY_WIDTH = 31,
    parameter int TABLE_DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 job_valid,
    output logic                                 job_ready,
    input  logic                                 job_func,
    input  logic [KEY_WIDTH-1:0]                 job_key,
    input  logic [lphi_pkg::CFG_W-1:0]           job_home,
    input  logic [lphi_pkg::CFG_W-1:0]           job_len,
    output logic                                 clearing,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_status,
    output logic [$clog2(TABLE_DEPTH)-1:0]       m_slot,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]     m_probe,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]     m_entry
);

    localparam int LEN_W = lphi_pkg::CFG_W;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] B_CLEAR = 2'd0;
    localparam logic [1:0] B_IDLE  = 2'd1;
    localparam logic [1:0] B_PROBE = 2'd2;
    localparam logic [1:0] B_DONE  = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [AW-1:0]        clr_reg;
    logic [CNT_W-1:0]     stored_reg;
    logic                 m_valid_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic                 func_reg;
    logic [AW-1:0]        home_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [AW-1:0]        addr_reg;
    logic [CNT_W-1:0]     c_reg;
    logic [1:0]           res_status_reg;
    logic [AW-1:0]        res_slot_reg;
    logic [CNT_W-1:0]     res_probe_reg;
    logic [CNT_W-1:0]     res_entry_reg;
    logic [1:0]           m_status_reg;
    logic [AW-1:0]        m_slot_reg;
    logic [CNT_W-1:0]     m_probe_reg;
    logic [CNT_W-1:0]     m_entry_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [KEY_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [KEY_WIDTH-1:0] ram_rdata;
    logic [AW-1:0]        next_addr;
    logic                 hit;
    logic                 empty;
    logic                 last;
    logic                 finish;
    logic                 do_insert;
    logic                 out_free;
    logic                 job_take;

    lphi_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // read data belongs to addr_reg; the next slot is fetched ahead of the compare
    assign hit       = (ram_rdata == key_reg);
    assign empty     = (ram_rdata == '0);
    assign last      = ((32'(c_reg) + 32'd1) == 32'(len_reg));
    assign next_addr = ((32'(addr_reg) + 32'd1) == 32'(len_reg)) ? '0 : addr_reg + AW'(1);
    assign finish    = (state_reg == B_PROBE) && (hit || empty || last);
    assign do_insert = (state_reg == B_PROBE) && !hit && empty && !func_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign job_ready = (state_reg == B_IDLE);
    assign job_take  = job_valid && job_ready;
    assign clearing  = (state_reg == B_CLEAR);

    assign ram_we    = clearing || do_insert;
    assign ram_waddr = clearing ? clr_reg : addr_reg;
    assign ram_wdata = clearing ? '0 : key_reg;
    assign ram_raddr = (state_reg == B_IDLE) ? AW'(job_home) : next_addr;

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_slot   = m_slot_reg;
    assign m_probe  = m_probe_reg;
    assign m_entry  = m_entry_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR:
            begin
                if (32'(clr_reg) == TABLE_DEPTH - 1)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = B_PROBE;
                end
            end
            B_PROBE:
            begin
                if (finish)
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_CLEAR;
            clr_reg     <= '0;
            stored_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (do_insert)
            begin
                stored_reg <= stored_reg + CNT_W'(1);
            end
            if (state_reg == B_DONE && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            key_reg  <= job_key;
            func_reg <= job_func;
            home_reg <= AW'(job_home);
            len_reg  <= job_len;
            addr_reg <= AW'(job_home);
            c_reg    <= '0;
        end
        if (state_reg == B_PROBE && !finish)
        begin
            addr_reg <= next_addr;
            c_reg    <= c_reg + CNT_W'(1);
        end
        if (finish)
        begin
            if (hit)
            begin
                res_status_reg <= lphi_pkg::ST_PRESENT;
                res_slot_reg   <= addr_reg;
                res_probe_reg  <= c_reg;
                res_entry_reg  <= stored_reg;
            end
            else if (empty && func_reg)
            begin
                res_status_reg <= lphi_pkg::ST_ABSENT;
                res_slot_reg   <= addr_reg;
                res_probe_reg  <= c_reg;
                res_entry_reg  <= stored_reg;
            end
            else if (empty)
            begin
                res_status_reg <= lphi_pkg::ST_INSERTED;
                res_slot_reg   <= addr_reg;
                res_probe_reg  <= c_reg;
                res_entry_reg  <= stored_reg + CNT_W'(1);
            end
            else
            begin
                // every slot in use: report the home slot
                res_status_reg <= lphi_pkg::ST_FULL;
                res_slot_reg   <= home_reg;
                res_probe_reg  <= CNT_W'(len_reg);
                res_entry_reg  <= stored_reg;
            end
        end
        if (state_reg == B_DONE && out_free)
        begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_probe_reg  <= res_probe_reg;
            m_entry_reg  <= res_entry_reg;
        end
    end

endmodule

@@ hdl/linear_probe_hash_insert.sv @@
// Linear probing hash table, insert and search; top level with APB registers.
// Front end: key remainder four bits a cycle, then length remainder; one item at a time.
// Back end: one table read a cycle while probing; a new item waits until the last result is registered.
// The two-entry queue between them lets the front end hash the next item during a probe.
// Reset clears control state, then a pass over all TABLE_DEPTH slots zeroes the table;
// no item is accepted during that pass. Depends on lphi_pkg, lphi_front, lphi_fifo, lphi_back.
module linear_probe_hash_insert #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_WIDTH = 31
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [lphi_pkg::REG_INDEX_W+1:0]            paddr,
    input  logic [31:0]                                 pwdata,
    output logic [31:0]                                 prdata,
    output logic                                        pready,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    // s_tdata: key
    input  logic [((KEY_WIDTH+7)/8)*8-1:0]              s_tdata,
    // s_tuser: func
    input  logic [0:0]                                  s_tuser,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    // m_tdata: slot, probe_count, entry_count
    output logic [((($clog2(TABLE_DEPTH)+2*$clog2(TABLE_DEPTH+1))+7)/8)*8-1:0] m_tdata,
    // m_tuser: status
    output logic [1:0]                                  m_tuser
);

    localparam int LEN_W = lphi_pkg::CFG_W;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_W = AW + 2 * CNT_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int JOB_W = 1 + KEY_WIDTH + 2 * LEN_W;

    logic [LEN_W-1:0]     modulus_reg;
    logic [LEN_W-1:0]     length_reg;
    lphi_pkg::cfg_t       cfg;
    logic                 cfg_write;
    logic                 clearing;

    logic                 fj_valid;
    logic                 fj_ready;
    logic                 fj_func;
    logic [KEY_WIDTH-1:0] fj_key;
    logic [LEN_W-1:0]     fj_home;
    logic [LEN_W-1:0]     fj_len;
    logic [JOB_W-1:0]     push_data;
    logic [JOB_W-1:0]     pop_data;
    logic                 bj_valid;
    logic                 bj_ready;
    logic [AW-1:0]        out_slot;
    logic [CNT_W-1:0]     out_probe;
    logic [CNT_W-1:0]     out_entry;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= lphi_pkg::MODULUS_RESET;
            length_reg  <= lphi_pkg::LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[lphi_pkg::REG_INDEX_W+1:2])
                lphi_pkg::REG_HASH_MODULUS: modulus_reg <= pwdata[LEN_W-1:0];
                lphi_pkg::REG_TABLE_LENGTH: length_reg  <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[lphi_pkg::REG_INDEX_W+1:2])
            lphi_pkg::REG_HASH_MODULUS: prdata = 32'(modulus_reg);
            lphi_pkg::REG_TABLE_LENGTH: prdata = 32'(length_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.hash_modulus = modulus_reg;
    assign cfg.table_length = length_reg;

    lphi_front #(
        .KEY_WIDTH   (KEY_WIDTH),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .block     (clearing),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser[0]),
        .in_key    (s_tdata[KEY_WIDTH-1:0]),
        .job_valid (fj_valid),
        .job_ready (fj_ready),
        .job_func  (fj_func),
        .job_key   (fj_key),
        .job_home  (fj_home),
        .job_len   (fj_len)
    );

    assign push_data = {fj_func, fj_key, fj_home, fj_len};

    lphi_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fj_valid),
        .push_ready (fj_ready),
        .push_data  (push_data),
        .pop_valid  (bj_valid),
        .pop_ready  (bj_ready),
        .pop_data   (pop_data)
    );

    lphi_back #(
        .KEY_WIDTH   (KEY_WIDTH),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (bj_valid),
        .job_ready (bj_ready),
        .job_func  (pop_data[JOB_W-1]),
        .job_key   (pop_data[JOB_W-2 -: KEY_WIDTH]),
        .job_home  (pop_data[2*LEN_W-1 -: LEN_W]),
        .job_len   (pop_data[LEN_W-1:0]),
        .clearing  (clearing),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_status  (m_tuser),
        .m_slot    (out_slot),
        .m_probe   (out_probe),
        .m_entry   (out_entry)
    );

    assign m_tdata = OUT_TDATA_W'({out_entry, out_probe, out_slot});

endmodule

@@ dv/tb_linear_probe_hash_insert.sv @@
// Self-checking testbench for linear_probe_hash_insert: directed and random insert/search
// traffic through the stream ports, register writes through APB. Depends on lphi_pkg.
module tb_linear_probe_hash_insert;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  SLOTS = 16;
    localparam int  LIMIT = 400000;
    localparam int  SETTLE = 40;
    localparam int  PHASES = 16;
    localparam int  PHASE_OPS = 50;
    localparam bit  OP_INSERT = 1'b0;
    localparam bit  OP_SEARCH = 1'b1;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] slot;
        logic [4:0] probes;
        logic [4:0] entries;
    } outcome_t;

    // Shadow of the hash table: keys, stored count, registers and pending outcomes
    class probe_table_model_t;
        logic [30:0] keys[SLOTS];
        int unsigned stored;
        logic [4:0]  modulus_reg;
        logic [4:0]  length_reg;
        outcome_t    outcome_q[$];
        int unsigned errors;
        int unsigned ops;
        int unsigned by_status[4];

        function new();
            foreach (keys[i])
                keys[i] = '0;
            stored = 0;
            modulus_reg = lphi_pkg::MODULUS_RESET;
            length_reg = lphi_pkg::LENGTH_RESET;
            errors = 0;
            ops = 0;
            foreach (by_status[i])
                by_status[i] = 0;
        endfunction

        function void set_register(logic [lphi_pkg::REG_INDEX_W-1:0] idx, logic [4:0] value);
            if (idx == lphi_pkg::REG_HASH_MODULUS)
                modulus_reg = value;
            else
                length_reg = value;
        endfunction

        // Walk the probe sequence and queue the outcome of one accepted transaction
        function void record_op(bit op, logic [30:0] key);
            int unsigned len;
            int unsigned divisor;
            int unsigned home;
            int unsigned c;
            int unsigned at;
            bit          stop;
            outcome_t    r;
            len = (length_reg == 0) ? 1 : ((length_reg > SLOTS) ? SLOTS : length_reg);
            divisor = (modulus_reg == 0) ? 1 : modulus_reg;
            home = (int'(key) % divisor) % len;
            r.status = lphi_pkg::ST_FULL;
            c = 0;
            at = home;
            stop = 1'b0;
            while (!stop && c < len)
            begin
                at = (home + c) % len;
                if (keys[at] == key)
                begin
                    r.status = lphi_pkg::ST_PRESENT;
                    stop = 1'b1;
                end
                else if (keys[at] == '0)
                begin
                    if (op == OP_INSERT)
                    begin
                        keys[at] = key;
                        stored++;
                        r.status = lphi_pkg::ST_INSERTED;
                    end
                    else
                        r.status = lphi_pkg::ST_ABSENT;
                    stop = 1'b1;
                end
                else
                    c++;
            end
            if (!stop)
                at = home;
            r.slot = at[3:0];
            r.probes = c[4:0];
            r.entries = stored[4:0];
            outcome_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_outcome(logic [1:0] st, logic [3:0] sl, logic [4:0] pc, logic [4:0] ec);
            outcome_t want;
            if (outcome_q.size() == 0)
            begin
                report($sformatf("unexpected result status=%0d slot=%0d", st, sl));
                return;
            end
            want = outcome_q.pop_front();
            ops++;
            by_status[want.status]++;
            if (st !== want.status)
                report($sformatf("op %0d status %0d, want %0d", ops, st, want.status));
            if (sl !== want.slot)
                report($sformatf("op %0d slot %0d, want %0d", ops, sl, want.slot));
            if (pc !== want.probes)
                report($sformatf("op %0d probe_count %0d, want %0d", ops, pc, want.probes));
            if (ec !== want.entries)
                report($sformatf("op %0d entry_count %0d, want %0d", ops, ec, want.entries));
        endtask
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [lphi_pkg::REG_INDEX_W+1:0] paddr = '0;
    logic [31:0]                      pwdata = '0;
    logic [31:0]                      prdata;
    logic                             pready;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [31:0]                      s_tdata = '0;   // key (bits 30:0), zero pad
    logic [0:0]                       s_tuser = '0;   // func
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [15:0]                      m_tdata;        // slot, probe_count, entry_count
    logic [1:0]                       m_tuser;        // status

    probe_table_model_t shadow = new();
    int unsigned        cycles = 0;
    int unsigned        settings = 0;
    bit                 no_gaps = 1'b0;

    linear_probe_hash_insert dut (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [lphi_pkg::REG_INDEX_W-1:0] idx,
                             input logic [4:0] value);
        logic [31:0] readback;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {27'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        shadow.set_register(idx, value);
        // read back in the following transfer
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        settings++;
        if (readback !== {27'd0, value})
            shadow.report($sformatf("register %0d reads %0h, want %0h", idx, readback, value));
    endtask

    task automatic send_op(input bit op, input logic [30:0] key);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, key};
        s_tuser <= op;
        do @(posedge clk); while (!s_tready);
        shadow.record_op(op, key);
    endtask

    // Drop valid, drain every outstanding result, then let the pipeline settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (shadow.outcome_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [30:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 18)
            return 31'($urandom());
        if (r < 22)
            return {1'b1, 30'($urandom_range(0, 63))};
        return 31'($urandom_range(1, 48));
    endfunction

    initial
    begin
        @(posedge clk);
        forever
        begin
            int stall;
            stall = no_gaps ? 0 : $urandom_range(0, 16);
            repeat (stall)
            begin
                m_tready <= 1'b0;
                @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            shadow.check_outcome(m_tuser, m_tdata[3:0], m_tdata[8:4], m_tdata[13:9]);
        end
    end

    initial
    begin
        logic [4:0] modv;
        logic [4:0] lenv;
        int         cap;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: search an empty table, zero key, collisions, widest key
        send_op(OP_SEARCH, 31'd13);
        send_op(OP_INSERT, 31'd0);
        send_op(OP_INSERT, 31'd13);
        send_op(OP_INSERT, 31'd26);
        send_op(OP_INSERT, 31'd13);
        send_op(OP_SEARCH, 31'd39);
        send_op(OP_SEARCH, 31'd0);
        send_op(OP_INSERT, 31'h7FFF_FFFF);
        send_op(OP_SEARCH, 31'h7FFF_FFFF);
        send_op(OP_INSERT, 31'd1);

        // Zero modulus on a short table: every home slot is 0 and both slots are already in use
        wait_idle();
        write_reg(lphi_pkg::REG_HASH_MODULUS, 5'd0);
        write_reg(lphi_pkg::REG_TABLE_LENGTH, 5'd2);
        send_op(OP_INSERT, 31'd5);
        send_op(OP_SEARCH, 31'd13);
        send_op(OP_SEARCH, 31'd7);
        send_op(OP_SEARCH, 31'd0);

        // Length above the table depth clamps to the full table
        wait_idle();
        write_reg(lphi_pkg::REG_HASH_MODULUS, 5'd16);
        write_reg(lphi_pkg::REG_TABLE_LENGTH, 5'd31);
        send_op(OP_SEARCH, 31'd15);
        send_op(OP_INSERT, 31'd16);
        send_op(OP_INSERT, 31'd31);
        send_op(OP_SEARCH, 31'd0);

        // Zero length acts as one slot
        wait_idle();
        write_reg(lphi_pkg::REG_HASH_MODULUS, 5'd1);
        write_reg(lphi_pkg::REG_TABLE_LENGTH, 5'd0);
        send_op(OP_INSERT, 31'd2);
        send_op(OP_SEARCH, 31'd13);
        send_op(OP_SEARCH, 31'd0);

        // Random phases; the length ceiling grows so the table fills gradually
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            cap = (phase + 2 > SLOTS) ? SLOTS : phase + 2;
            case (phase)
                3:       modv = 5'd0;
                5:       modv = 5'd31;
                7:       modv = 5'd16;
                9:       modv = 5'd1;
                default: modv = 5'($urandom_range(0, 31));
            endcase
            case (phase)
                2:       lenv = 5'd0;
                13:      lenv = 5'd16;
                15:      lenv = 5'd31;
                default: lenv = 5'($urandom_range(1, cap));
            endcase
            write_reg(lphi_pkg::REG_HASH_MODULUS, modv);
            write_reg(lphi_pkg::REG_TABLE_LENGTH, lenv);
            no_gaps = (phase % 4 == 1);
            repeat (PHASE_OPS)
                send_op(($urandom_range(0, 9) < 4) ? OP_SEARCH : OP_INSERT, pick_key());
        end

        wait_idle();
        if (shadow.outcome_q.size() != 0)
            shadow.report("results still outstanding at end of run");
        $display("Ran %0d operations across %0d register writes, %0d keys stored",
                 shadow.ops, settings, shadow.stored);
        $display("Outcomes: %0d inserted, %0d present, %0d absent, %0d table full",
                 shadow.by_status[lphi_pkg::ST_INSERTED], shadow.by_status[lphi_pkg::ST_PRESENT],
                 shadow.by_status[lphi_pkg::ST_ABSENT], shadow.by_status[lphi_pkg::ST_FULL]);
        if (shadow.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
